@@ hdl/rrt_pkg.sv @@
// ----------------------------------------------------------------------------
// rrt_pkg: shared definitions for the register rename table
// Sizes of the rename map and of virtual names, instruction class codes and
// the allocation bundle passed from the name allocator to the control.
// ----------------------------------------------------------------------------
package rrt_pkg;

  // Number of architectural registers. It must be a power of two, so that a
  // register number is reduced to a map index by dropping its upper bits.
  localparam int SOURCE_REGS = 256;
  localparam int IDX_W       = $clog2(SOURCE_REGS);

  // Width of a virtual name as held in the map and the name counter.
  localparam int NAME_WIDTH  = 16;

  // Fixed widths of the ports.
  localparam int REG_W       = 8;
  localparam int MODE_W      = 3;
  localparam int VREG_W      = 16;

  localparam logic [NAME_WIDTH-1:0] NAME_TOP = '1;

  // Instruction classes. Any other code behaves as MODE_OTHER.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STORE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOADI = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ALU   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OTHER = 3'd4;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [NAME_WIDTH-1:0] name_t;

  // Up to three names handed out in one instruction, the counter value that
  // follows them and whether the top name was handed out.
  typedef struct packed {
    name_t [2:0] names;
    name_t       next;
    logic        over;
  } alloc_t;

endpackage

@@ hdl/rrt_map_ram.sv @@
// ----------------------------------------------------------------------------
// rrt_map_ram: rename map storage
// Single write port and two read ports, each read registered, so that data
// appears in the cycle after the read is enabled and then holds.
// ----------------------------------------------------------------------------
module rrt_map_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hdl/rrt_name_alloc.sv @@
// ----------------------------------------------------------------------------
// rrt_name_alloc: saturating virtual name allocator
// Given the counter value and the number of names one instruction takes,
// gives every name in order, the following counter value and whether the top
// name was handed out.
// ----------------------------------------------------------------------------
module rrt_name_alloc (
  input  rrt_pkg::name_t base,
  input  logic [1:0]     count,
  output rrt_pkg::alloc_t alloc
);

  localparam int SUM_W = rrt_pkg::NAME_WIDTH + 2;

  logic [SUM_W-1:0] sum [4];
  rrt_pkg::name_t   sat [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = {2'b00, base} + SUM_W'(j);
      sat[j] = (sum[j] > {2'b00, rrt_pkg::NAME_TOP}) ? rrt_pkg::NAME_TOP
                                                     : sum[j][rrt_pkg::NAME_WIDTH-1:0];
    end
  end

  always_comb begin
    alloc.names[0] = sat[0];
    alloc.names[1] = sat[1];
    alloc.names[2] = sat[2];
    alloc.next     = sat[count];
    // The last name taken was the top one exactly when base + count passes it.
    alloc.over     = (count != 2'd0) && (sum[count] > {2'b00, rrt_pkg::NAME_TOP});
  end

endmodule

@@ hdl/register_rename_table.sv @@
// ----------------------------------------------------------------------------
// register_rename_table: architectural to virtual register renaming
// Looks up and updates the rename map for one instruction per input beat.
// ----------------------------------------------------------------------------
// Usage
// An instruction beat (class, three register numbers with present bits and a
// start-of-block flag) is taken on in_valid/in_ready. The block answers with
// one result beat on out_valid/out_ready carrying the virtual names of the
// operands and the names_exhausted flag, sticky within a block.
// Timing: the beat cycle reads the map, the next cycle resolves the operands
// in order and allocates names, then the write state writes each map entry
// that changes (zero to three) through the single write port of the map
// memory, one after another; it loads the output register with the last of
// these, or on entry if there are none, when the output register is free.
// A new input beat is taken only after the write state has finished.
// The result waits in the output register while the next instruction is
// already being renamed; if the receiver stalls, the block holds its finished
// result internally and takes no new beat until the output register is free.
// Reset clears every map valid bit, the name counter and the flag; the map
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module register_rename_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start_of_block,
  input  logic [rrt_pkg::MODE_W-1:0]    mode,
  input  logic [rrt_pkg::REG_W-1:0]     first_src,
  input  logic                          first_present,
  input  logic [rrt_pkg::REG_W-1:0]     second_src,
  input  logic                          second_present,
  input  logic [rrt_pkg::REG_W-1:0]     third_reg,
  input  logic                          third_present,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrt_pkg::VREG_W-1:0]    first_vreg,
  output logic                          first_vreg_valid,
  output logic [rrt_pkg::VREG_W-1:0]    second_vreg,
  output logic                          second_vreg_valid,
  output logic [rrt_pkg::VREG_W-1:0]    third_vreg,
  output logic                          third_vreg_valid,
  output logic                          names_exhausted
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0] state;

  // Captured instruction.
  logic                       start_q;
  logic [rrt_pkg::MODE_W-1:0] mode_q;
  rrt_pkg::idx_t              idx1_q, idxb_q, idx3_q;
  logic                       p1_q, p2_q, p3_q;

  // Map state outside the memory.
  logic [rrt_pkg::SOURCE_REGS-1:0] map_valid, map_valid_next;
  rrt_pkg::name_t                  next_name;
  logic                            exhausted;

  // Results and pending map writes of the current instruction.
  rrt_pkg::name_t res_v1, res_vb, res_v3;
  logic           res_ok1, res_ok2, res_ok3, res_store;
  logic [2:0]     pend, pend_next, pick;
  rrt_pkg::idx_t  wr_addr [3];
  rrt_pkg::name_t wr_data [3];

  logic           accept, out_free;
  rrt_pkg::idx_t  rd_idx_b;
  rrt_pkg::name_t rd_a, rd_b;

  // Operand resolution.
  logic            use1, useb, def3, vld1, vldb, fwd, alloc1, allocb;
  logic [1:0]      count, def_pos;
  rrt_pkg::name_t  base, v1, vb, v3;
  rrt_pkg::alloc_t alloc;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign rd_idx_b = rrt_pkg::idx_t'((mode == rrt_pkg::MODE_STORE) ? third_reg : second_src);

  rrt_map_ram #(
    .DEPTH (rrt_pkg::SOURCE_REGS),
    .WIDTH (rrt_pkg::NAME_WIDTH)
  ) u_map (
    .clk     (clk),
    .we      ((state == S_WRITE) && (pend != 3'b000)),
    .waddr   (pick[0] ? wr_addr[0] : (pick[1] ? wr_addr[1] : wr_addr[2])),
    .wdata   (pick[0] ? wr_data[0] : (pick[1] ? wr_data[1] : wr_data[2])),
    .re      (accept),
    .raddr_a (rrt_pkg::idx_t'(first_src)),
    .rdata_a (rd_a),
    .raddr_b (rd_idx_b),
    .rdata_b (rd_b)
  );

  rrt_name_alloc u_alloc (
    .base  (base),
    .count (count),
    .alloc (alloc)
  );

  // Resolve first use, second use (the third register for a store), then the
  // definition. A start of block makes every entry read as unseen.
  always_comb begin
    base   = start_q ? '0 : next_name;
    use1   = p1_q && (mode_q inside {rrt_pkg::MODE_LOAD, rrt_pkg::MODE_STORE,
                                     rrt_pkg::MODE_ALU});
    useb   = ((mode_q == rrt_pkg::MODE_ALU) && p2_q) ||
             ((mode_q == rrt_pkg::MODE_STORE) && p3_q);
    def3   = p3_q && (mode_q inside {rrt_pkg::MODE_LOAD, rrt_pkg::MODE_LOADI,
                                     rrt_pkg::MODE_ALU});
    vld1   = !start_q && map_valid[idx1_q];
    vldb   = !start_q && map_valid[idxb_q];
    alloc1 = use1 && !vld1;
    // A second use of the register just seen takes the first result, since the
    // memory read predates any allocation made for the first use.
    fwd    = use1 && (idxb_q == idx1_q);
    allocb = useb && !fwd && !vldb;
    count  = 2'({1'b0, alloc1} + {1'b0, allocb} + {1'b0, def3});
    def_pos = 2'({1'b0, alloc1} + {1'b0, allocb});

    v1 = alloc1 ? alloc.names[0] : rd_a;
    if (fwd) begin
      vb = v1;
    end else if (vldb) begin
      vb = rd_b;
    end else begin
      vb = alloc1 ? alloc.names[1] : alloc.names[0];
    end
    v3 = alloc.names[def_pos];

    map_valid_next = start_q ? '0 : map_valid;
    if (alloc1) begin
      map_valid_next[idx1_q] = 1'b1;
    end
    if (allocb) begin
      map_valid_next[idxb_q] = 1'b1;
    end
    if (def3) begin
      map_valid_next[idx3_q] = 1'b1;
    end
  end

  // Writes go out in operand order so that a definition lands last.
  always_comb begin
    pick      = pend & (~pend + 3'd1);
    pend_next = pend & ~pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      map_valid <= '0;
      next_name <= '0;
      exhausted <= 1'b0;
      pend      <= 3'b000;
    end else begin
      if ((state == S_WRITE) && (pend_next == 3'b000) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          map_valid <= map_valid_next;
          next_name <= alloc.next;
          exhausted <= (!start_q && exhausted) || alloc.over;
          pend      <= {def3, allocb, alloc1};
          state     <= S_WRITE;
        end
        S_WRITE: begin
          pend <= pend_next;
          if ((pend_next == 3'b000) && out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_q <= start_of_block;
      mode_q  <= mode;
      idx1_q  <= rrt_pkg::idx_t'(first_src);
      idxb_q  <= rd_idx_b;
      idx3_q  <= rrt_pkg::idx_t'(third_reg);
      p1_q    <= first_present;
      p2_q    <= second_present;
      p3_q    <= third_present;
    end
    if (state == S_LOOK) begin
      res_v1     <= v1;
      res_vb     <= vb;
      res_v3     <= v3;
      res_ok1    <= use1;
      res_ok2    <= useb && (mode_q == rrt_pkg::MODE_ALU);
      res_ok3    <= def3 || (useb && (mode_q == rrt_pkg::MODE_STORE));
      res_store  <= (mode_q == rrt_pkg::MODE_STORE);
      wr_addr[0] <= idx1_q;
      wr_data[0] <= v1;
      wr_addr[1] <= idxb_q;
      wr_data[1] <= vb;
      wr_addr[2] <= idx3_q;
      wr_data[2] <= v3;
    end
    if ((state == S_WRITE) && (pend_next == 3'b000) && out_free) begin
      first_vreg        <= res_ok1 ? rrt_pkg::VREG_W'(res_v1) : '0;
      first_vreg_valid  <= res_ok1;
      second_vreg       <= res_ok2 ? rrt_pkg::VREG_W'(res_vb) : '0;
      second_vreg_valid <= res_ok2;
      third_vreg        <= !res_ok3 ? '0 :
                           (res_store ? rrt_pkg::VREG_W'(res_vb) : rrt_pkg::VREG_W'(res_v3));
      third_vreg_valid  <= res_ok3;
      names_exhausted   <= exhausted;
    end
  end

endmodule

@@ hdl/rrt_checker.sv @@
// ----------------------------------------------------------------------------
// rrt_checker: port-level checks for the register rename table
// Watches the two channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module rrt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rrt_pkg::VREG_W-1:0] first_vreg,
  input logic                       first_vreg_valid,
  input logic [rrt_pkg::VREG_W-1:0] second_vreg,
  input logic                       second_vreg_valid,
  input logic [rrt_pkg::VREG_W-1:0] third_vreg,
  input logic                       third_vreg_valid,
  input logic                       names_exhausted
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_vreg) &&
      $stable(second_vreg) && $stable(third_vreg) && $stable(names_exhausted))
    else $error("result beat changed while stalled");

  // Operands that were not renamed read as zero.
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (first_vreg_valid || first_vreg == '0) &&
      (second_vreg_valid || second_vreg == '0) && (third_vreg_valid || third_vreg == '0))
    else $error("absent operand carries a non-zero name");

  // One instruction at a time: the cycle after a beat is taken is busy.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  // Nothing is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind register_rename_table rrt_checker u_rrt_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .first_vreg        (first_vreg),
  .first_vreg_valid  (first_vreg_valid),
  .second_vreg       (second_vreg),
  .second_vreg_valid (second_vreg_valid),
  .third_vreg        (third_vreg),
  .third_vreg_valid  (third_vreg_valid),
  .names_exhausted   (names_exhausted)
);

@@ bench/register_rename_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_rename_table_tb: self-checking bench for the register rename table
// Sends instruction beats through the input handshake and keeps its own
// rename map, name counter and exhausted flag to work out the names that each
// instruction must receive. Every result beat is compared field by field with
// the oldest outstanding prediction. The run covers a directed set of corner
// cases, a long random stream with stalls on both sides, a stream heavy in
// definitions that moves the name counter along quickly, and a calm stream.
// ----------------------------------------------------------------------------
module register_rename_table_tb;

  localparam logic [rrt_pkg::MODE_W-1:0] MODE_SPARE_LO = rrt_pkg::MODE_OTHER + 1'b1;
  localparam logic [rrt_pkg::MODE_W-1:0] MODE_SPARE_HI = '1;
  localparam int STUCK_LIMIT  = 4000;
  localparam int RANDOM_BEATS = 1120;
  localparam int DEFINE_BEATS = 60;
  localparam int CALM_BEATS   = 200;
  localparam int PAUSE_EVERY  = 300;
  localparam int MAX_REPORTS  = 40;

  typedef logic [rrt_pkg::VREG_W-1:0] vreg_t;
  typedef logic [rrt_pkg::REG_W-1:0]  reg_t;

  typedef struct packed {
    logic                       sob;
    logic [rrt_pkg::MODE_W-1:0] mode;
    reg_t                       r1;
    logic                       p1;
    reg_t                       r2;
    logic                       p2;
    reg_t                       r3;
    logic                       p3;
  } instr_t;

  typedef struct packed {
    vreg_t v1;
    logic  ok1;
    vreg_t v2;
    logic  ok2;
    vreg_t v3;
    logic  ok3;
    logic  exh;
  } rename_t;

  logic                       clk            = 1'b0;
  logic                       rst            = 1'b1;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic                       start_of_block = 1'b0;
  logic [rrt_pkg::MODE_W-1:0] mode           = rrt_pkg::MODE_OTHER;
  reg_t                       first_src      = '0;
  logic                       first_present  = 1'b0;
  reg_t                       second_src     = '0;
  logic                       second_present = 1'b0;
  reg_t                       third_reg      = '0;
  logic                       third_present  = 1'b0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  vreg_t                      first_vreg;
  logic                       first_vreg_valid;
  vreg_t                      second_vreg;
  logic                       second_vreg_valid;
  vreg_t                      third_vreg;
  logic                       third_vreg_valid;
  logic                       names_exhausted;

  register_rename_table DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .start_of_block    (start_of_block),
    .mode              (mode),
    .first_src         (first_src),
    .first_present     (first_present),
    .second_src        (second_src),
    .second_present    (second_present),
    .third_reg         (third_reg),
    .third_present     (third_present),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .first_vreg        (first_vreg),
    .first_vreg_valid  (first_vreg_valid),
    .second_vreg       (second_vreg),
    .second_vreg_valid (second_vreg_valid),
    .third_vreg        (third_vreg),
    .third_vreg_valid  (third_vreg_valid),
    .names_exhausted   (names_exhausted)
  );

  always #1 clk = ~clk;

  // Shadow copy of the rename map and the name allocator.
  rrt_pkg::name_t alias_name [rrt_pkg::SOURCE_REGS];
  logic           alias_live [rrt_pkg::SOURCE_REGS];
  rrt_pkg::name_t name_ctr;
  logic           names_gone;

  rename_t expected_q[$];
  int      err_count       = 0;
  int      beats_sent      = 0;
  int      define_sent     = 0;
  int      results_checked = 0;
  int      stuck_cycles    = 0;
  int      stall_left      = 0;
  bit      idle_on         = 1'b1;

  function automatic void clear_map();
    foreach (alias_live[i]) alias_live[i] = 1'b0;
    name_ctr   = '0;
    names_gone = 1'b0;
  endfunction

  // Once the counter sits at the top value it keeps handing that value out.
  function automatic rrt_pkg::name_t grab_name();
    rrt_pkg::name_t n;
    n = name_ctr;
    if (n != rrt_pkg::NAME_TOP) name_ctr = n + 1'b1;
    else names_gone = 1'b1;
    return n;
  endfunction

  function automatic rrt_pkg::name_t lookup_or_grab(reg_t r);
    rrt_pkg::idx_t i;
    i = rrt_pkg::idx_t'(r % rrt_pkg::SOURCE_REGS);
    if (!alias_live[i]) begin
      alias_name[i] = grab_name();
      alias_live[i] = 1'b1;
    end
    return alias_name[i];
  endfunction

  function automatic rrt_pkg::name_t define_reg(reg_t r);
    rrt_pkg::idx_t i;
    i = rrt_pkg::idx_t'(r % rrt_pkg::SOURCE_REGS);
    alias_name[i] = grab_name();
    alias_live[i] = 1'b1;
    return alias_name[i];
  endfunction

  function automatic rename_t rename_instr(instr_t it);
    rename_t res;
    logic    use1;
    logic    use2;
    logic    def3;
    logic    use3;
    res  = '0;
    use1 = (it.mode == rrt_pkg::MODE_LOAD) || (it.mode == rrt_pkg::MODE_STORE) ||
           (it.mode == rrt_pkg::MODE_ALU);
    use2 = (it.mode == rrt_pkg::MODE_ALU);
    def3 = (it.mode == rrt_pkg::MODE_LOAD) || (it.mode == rrt_pkg::MODE_LOADI) ||
           (it.mode == rrt_pkg::MODE_ALU);
    use3 = (it.mode == rrt_pkg::MODE_STORE);
    if (it.sob) clear_map();
    // The order matters: first use, second use, then the third register.
    if (use1 && it.p1) begin
      res.v1  = vreg_t'(lookup_or_grab(it.r1));
      res.ok1 = 1'b1;
    end
    if (use2 && it.p2) begin
      res.v2  = vreg_t'(lookup_or_grab(it.r2));
      res.ok2 = 1'b1;
    end
    if (it.p3 && def3) begin
      res.v3  = vreg_t'(define_reg(it.r3));
      res.ok3 = 1'b1;
    end else if (it.p3 && use3) begin
      res.v3  = vreg_t'(lookup_or_grab(it.r3));
      res.ok3 = 1'b1;
    end
    res.exh = names_gone;
    return res;
  endfunction

  function automatic instr_t mk_instr(int sob, logic [rrt_pkg::MODE_W-1:0] md, int r1, int p1,
                                      int r2, int p2, int r3, int p3);
    instr_t it;
    it.sob  = 1'(sob);
    it.mode = md;
    it.r1   = reg_t'(r1);
    it.p1   = 1'(p1);
    it.r2   = reg_t'(r2);
    it.p2   = 1'(p2);
    it.r3   = reg_t'(r3);
    it.p3   = 1'(p3);
    return it;
  endfunction

  // Half the register numbers come from a small pool so that uses hit the map.
  function automatic reg_t random_reg();
    if ($urandom_range(0, 1) == 0) return reg_t'($urandom_range(0, 15));
    return reg_t'($urandom_range(0, rrt_pkg::SOURCE_REGS - 1));
  endfunction

  function automatic logic [rrt_pkg::MODE_W-1:0] random_spare_mode();
    return rrt_pkg::MODE_W'($urandom_range(int'(MODE_SPARE_LO), int'(MODE_SPARE_HI)));
  endfunction

  function automatic instr_t random_instr(int sob_pct);
    instr_t it;
    int     pick;
    pick   = $urandom_range(0, 99);
    it.sob = ($urandom_range(0, 99) < sob_pct);
    if (pick < 6) it.mode = random_spare_mode();
    else if (pick < 12) it.mode = rrt_pkg::MODE_OTHER;
    else begin
      case ($urandom_range(0, 3))
        0:       it.mode = rrt_pkg::MODE_LOAD;
        1:       it.mode = rrt_pkg::MODE_STORE;
        2:       it.mode = rrt_pkg::MODE_LOADI;
        default: it.mode = rrt_pkg::MODE_ALU;
      endcase
    end
    it.r1 = random_reg();
    it.r2 = random_reg();
    it.r3 = random_reg();
    it.p1 = ($urandom_range(0, 99) < 85);
    it.p2 = ($urandom_range(0, 99) < 85);
    it.p3 = ($urandom_range(0, 99) < 85);
    return it;
  endfunction

  // Called just after the clock rises; returns at the clock rise that takes the beat.
  task automatic send_instr(instr_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    start_of_block <= it.sob;
    mode           <= it.mode;
    first_src      <= it.r1;
    first_present  <= it.p1;
    second_src     <= it.r2;
    second_present <= it.p2;
    third_reg      <= it.r3;
    third_present  <= it.p3;
    expected_q.push_back(rename_instr(it));
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic test_directed();
    send_instr(mk_instr(1, rrt_pkg::MODE_LOADI, 0, 0, 0, 0, 0, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_LOAD, 0, 1, 255, 1, 255, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_STORE, 7, 1, 0, 1, 7, 1));
    // Same register as both sources and as the destination.
    send_instr(mk_instr(0, rrt_pkg::MODE_ALU, 5, 1, 5, 1, 5, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_ALU, 5, 1, 255, 1, 0, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_ALU, 255, 0, 255, 0, 255, 0));
    send_instr(mk_instr(0, rrt_pkg::MODE_OTHER, 255, 1, 255, 1, 255, 1));
    send_instr(mk_instr(0, MODE_SPARE_LO, 1, 1, 2, 1, 3, 1));
    send_instr(mk_instr(0, MODE_SPARE_LO + 1'b1, 255, 1, 255, 1, 255, 1));
    send_instr(mk_instr(0, MODE_SPARE_HI, 0, 1, 0, 1, 0, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_LOADI, 9, 1, 9, 1, 9, 0));
    send_instr(mk_instr(0, rrt_pkg::MODE_LOAD, 0, 0, 3, 1, 3, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_STORE, 200, 1, 201, 1, 3, 0));
    send_instr(mk_instr(0, rrt_pkg::MODE_STORE, 3, 0, 0, 0, 3, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_ALU, 128, 1, 0, 0, 128, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_ALU, 128, 1, 128, 1, 0, 1));
    send_instr(mk_instr(1, rrt_pkg::MODE_ALU, 0, 1, 255, 1, 128, 1));
    send_instr(mk_instr(1, rrt_pkg::MODE_OTHER, 0, 0, 0, 0, 0, 0));
    send_instr(mk_instr(0, rrt_pkg::MODE_STORE, 0, 1, 0, 0, 0, 1));
    send_instr(mk_instr(1, MODE_SPARE_HI, 255, 1, 255, 1, 255, 1));
    send_instr(mk_instr(0, rrt_pkg::MODE_LOAD, 255, 1, 0, 0, 255, 1));
    send_instr(mk_instr(1, rrt_pkg::MODE_LOADI, 0, 0, 0, 0, 128, 1));
    wait_for_results();
  endtask

  task automatic test_random_stream();
    for (int n = 1; n <= RANDOM_BEATS; n++) begin
      send_instr(random_instr(2));
      if (n % PAUSE_EVERY == 0) wait_for_results();
    end
  endtask

  // Every destination takes a fresh name, so the counter climbs quickly and
  // redefinitions of the same register overwrite the map over and over.
  task automatic test_define_heavy();
    instr_t it;
    send_instr(mk_instr(1, rrt_pkg::MODE_LOADI, 0, 0, 0, 0, int'(random_reg()), 1));
    repeat (DEFINE_BEATS) begin
      it = random_instr(0);
      it.mode = ($urandom_range(0, 3) == 0) ? rrt_pkg::MODE_ALU : rrt_pkg::MODE_LOADI;
      it.p3 = 1'b1;
      send_instr(it);
      define_sent++;
    end
    repeat (40) send_instr(random_instr(0));
    send_instr(mk_instr(1, rrt_pkg::MODE_STORE, int'(random_reg()), 1, 0, 0,
                        int'(random_reg()), 1));
  endtask

  task automatic test_calm_stream();
    repeat (CALM_BEATS) send_instr(random_instr(2));
  endtask

  task automatic check_field(string field, vreg_t want, vreg_t got);
    if (got !== want) begin
      if (err_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rename_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("%0t: result beat with nothing expected, actual names %0h %0h %0h",
                   $time, first_vreg, second_vreg, third_vreg);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("first_vreg", want.v1, first_vreg);
        check_field("first_vreg_valid", vreg_t'(want.ok1), vreg_t'(first_vreg_valid));
        check_field("second_vreg", want.v2, second_vreg);
        check_field("second_vreg_valid", vreg_t'(want.ok2), vreg_t'(second_vreg_valid));
        check_field("third_vreg", want.v3, third_vreg);
        check_field("third_vreg_valid", vreg_t'(want.ok3), vreg_t'(third_vreg_valid));
        check_field("names_exhausted", vreg_t'(want.exh), vreg_t'(names_exhausted));
        results_checked++;
      end
    end
  end

  // Ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clear_map();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_stream();
    idle_on = 1'b0;
    test_define_heavy();
    test_calm_stream();
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Renamed %0d instructions, %0d of them definition-heavy; %0d results compared.",
             beats_sent, define_sent, results_checked);
    $display("Covered all classes, spare codes, absent operands, repeated registers and block starts.");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rrt_pkg.sv
hdl/rrt_map_ram.sv
hdl/rrt_name_alloc.sv
hdl/register_rename_table.sv
hdl/rrt_checker.sv
bench/register_rename_table_tb.sv
